FILE: hw/rtl/agpid_pkg.sv
package agpid_pkg;

  // Default parameter values
  localparam int unsigned ERROR_WIDTH_DEF = 16;
  localparam int unsigned GAIN_WIDTH_DEF  = 32;

  // Fixed-point layout
  localparam int unsigned FRAC_SHIFT = 12;  // fraction bits of the error format
  localparam int unsigned WIDE_W     = 63;  // width of a gain-step product
  localparam int unsigned TERM_W     = 61;  // width of one drive term
  localparam int unsigned DIG_W      = 16;  // multiplier digit width
  localparam int unsigned OUT_W      = 32;  // drive and total_error width

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic signed [31:0] INIT_KP_RST  = 32'sd32768;
  localparam logic signed [31:0] INIT_KI_RST  = 32'sd0;
  localparam logic signed [31:0] INIT_KD_RST  = 32'sd65536;
  localparam logic [2:0]         EN_MASK_RST  = 3'd7;
  localparam logic [15:0]        LRATE_RST    = 16'd4506;
  localparam logic [14:0]        DBAND_RST    = 15'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INIT_KP   = 3'd0,
    CFG_INIT_KI   = 3'd1,
    CFG_INIT_KD   = 3'd2,
    CFG_EN_MASK   = 3'd3,
    CFG_LRATE     = 3'd4,
    CFG_DEAD_BAND = 3'd5
  } cfg_idx_e;

  // One entry per product in the order the sequencer issues them
  typedef enum logic [3:0] {
    SEL_P1    = 4'd0,
    SEL_P2    = 4'd1,
    SEL_P3    = 4'd2,
    SEL_I1    = 4'd3,
    SEL_I2    = 4'd4,
    SEL_I3    = 4'd5,
    SEL_D1    = 4'd6,
    SEL_D2    = 4'd7,
    SEL_D3    = 4'd8,
    SEL_DRV_P = 4'd9,
    SEL_DRV_I = 4'd10,
    SEL_DRV_D = 4'd11
  } mul_sel_e;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_RELOAD = 3'd1,
    ST_FIRST  = 3'd2,
    ST_TERMS  = 3'd3,
    ST_START  = 3'd4,
    ST_WAIT   = 3'd5,
    ST_OUT    = 3'd6
  } ctrl_state_e;

  typedef struct packed {
    logic     capture;    // take the error sample of the accepted beat
    logic     reload;     // load initial gains, clear terms
    logic     first;      // record P only
    logic     terms;      // update P, I, D and their changes
    logic     mul_start;  // launch a product on the shared multiplier
    logic     wb;         // write back the finished product
    logic     out_load;   // form the result beat
    mul_sel_e sel;        // which product
  } dp_cmd_t;

  typedef struct packed {
    logic first_pending;
    logic adapt;          // error above the dead band
    logic mul_done;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: hw/rtl/agpid_mul.sv
module agpid_mul #(
  parameter int unsigned B_W = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic                                 narrow_i,
  input  logic signed [agpid_pkg::WIDE_W-1:0]  a_i,
  input  logic signed [B_W-1:0]                b_i,
  output logic signed [agpid_pkg::WIDE_W-1:0]  res_o,
  output logic                                 done_o
);
  import agpid_pkg::*;

  localparam int unsigned NDIG   = (B_W + DIG_W - 1) / DIG_W;
  localparam int unsigned BP_W   = NDIG * DIG_W;
  localparam int unsigned PP_W   = WIDE_W + DIG_W;
  localparam int unsigned PROD_W = WIDE_W + BP_W;
  localparam int unsigned MAG_W  = PROD_W - FRAC_SHIFT;
  localparam int unsigned CNT_W  = $clog2(NDIG + 1);

  logic [WIDE_W-1:0] a_mag_q;
  logic [BP_W-1:0]   b_mag_q;
  logic              neg_q, narrow_q;
  logic [PROD_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              run_q, run_d, fin_q, fin_d, done_q, done_d;
  logic signed [WIDE_W-1:0] res_q;

  logic [WIDE_W-1:0] a_abs;
  logic [B_W-1:0]    b_abs;
  logic [DIG_W-1:0]  dig;
  logic [PP_W-1:0]   pp;
  logic [MAG_W-1:0]  mag;
  logic [WIDE_W-1:0] lim, sat_mag;

  assign a_abs = a_i[WIDE_W-1] ? WIDE_W'(-a_i) : WIDE_W'(a_i);
  assign b_abs = b_i[B_W-1] ? B_W'(-b_i) : B_W'(b_i);

  // Most significant digit first: acc = acc * 2^16 + |a| * digit
  assign dig   = b_mag_q[BP_W-1 -: DIG_W];
  assign pp    = PP_W'(a_mag_q) * PP_W'(dig);
  assign acc_d = {acc_q[PROD_W-DIG_W-1:0], {DIG_W{1'b0}}} + PROD_W'(pp);

  // Truncate toward zero on the magnitude, then clamp to the signed range
  assign mag     = acc_q[PROD_W-1:FRAC_SHIFT];
  assign lim     = (WIDE_W'(1) << (narrow_q ? TERM_W - 1 : WIDE_W - 1)) - WIDE_W'(!neg_q);
  assign sat_mag = (mag > MAG_W'(lim)) ? lim : mag[WIDE_W-1:0];

  always_comb begin
    run_d  = run_q;
    fin_d  = 1'b0;
    cnt_d  = cnt_q;
    done_d = fin_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = CNT_W'(NDIG - 1);
    end else if (run_q) begin
      if (cnt_q == '0) begin
        run_d = 1'b0;
        fin_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      fin_q  <= fin_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_mag_q  <= a_abs;
      b_mag_q  <= BP_W'(b_abs);
      neg_q    <= a_i[WIDE_W-1] ^ b_i[B_W-1];
      narrow_q <= narrow_i;
      acc_q    <= '0;
    end else if (run_q) begin
      acc_q   <= acc_d;
      b_mag_q <= b_mag_q << DIG_W;
    end
    if (fin_q) begin
      res_q <= neg_q ? WIDE_W'(-sat_mag) : WIDE_W'(sat_mag);
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

FILE: hw/rtl/agpid_dp.sv
module agpid_dp #(
  parameter int unsigned ERROR_WIDTH = agpid_pkg::ERROR_WIDTH_DEF,
  parameter int unsigned GAIN_WIDTH  = agpid_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [agpid_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [agpid_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic signed [ERROR_WIDTH-1:0]          in_err_i,
  input  agpid_pkg::dp_cmd_t                     cmd_i,
  output agpid_pkg::dp_sts_t                     sts_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [agpid_pkg::OUT_W-1:0]     drive_o,
  output logic signed [agpid_pkg::OUT_W-1:0]     total_o
);
  import agpid_pkg::*;

  localparam int unsigned B_W   = (ERROR_WIDTH + 2 > 32) ? ERROR_WIDTH + 2 : 32;
  localparam int unsigned CMP_W = ((ERROR_WIDTH > 15) ? ERROR_WIDTH : 16) + 1;
  localparam logic signed [63:0] GAIN_MAX = (64'sd1 <<< (GAIN_WIDTH - 1)) - 64'sd1;
  localparam logic signed [63:0] GAIN_MIN = -GAIN_MAX - 64'sd1;
  localparam logic signed [63:0] OUT_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] OUT_MIN  = -64'sd2147483648;

  function automatic logic signed [GAIN_WIDTH-1:0] gsat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > GAIN_MAX) ? GAIN_MAX : ((v < GAIN_MIN) ? GAIN_MIN : v);
    return r[GAIN_WIDTH-1:0];
  endfunction

  function automatic logic signed [OUT_W-1:0] osat(input logic signed [63:0] v);
    logic signed [63:0] r;
    r = (v > OUT_MAX) ? OUT_MAX : ((v < OUT_MIN) ? OUT_MIN : v);
    return r[OUT_W-1:0];
  endfunction

  // Configuration
  logic signed [31:0] init_kp_q, init_ki_q, init_kd_q;
  logic [2:0]         en_mask_q;
  logic [15:0]        lrate_q;
  logic [14:0]        dband_q;

  // Controller state
  logic                          first_q;
  logic signed [ERROR_WIDTH-1:0] prop_q;
  logic signed [31:0]            integ_q;
  logic signed [ERROR_WIDTH:0]   deriv_q;
  logic signed [GAIN_WIDTH-1:0]  gain_p_q, gain_i_q, gain_d_q;

  // Working registers
  logic signed [ERROR_WIDTH-1:0] err_q;
  logic signed [B_W-1:0]         chg_p_q, chg_i_q, chg_d_q;
  logic signed [WIDE_W-1:0]      t_q;
  logic signed [WIDE_W-1:0]      sum_q;
  logic signed [OUT_W-1:0]       drive_q, total_q;
  logic                          out_vld_q;

  logic signed [32:0]            integ_sum;
  logic signed [31:0]            integ_new;
  logic signed [ERROR_WIDTH:0]   deriv_new;
  logic signed [CMP_W-1:0]       err_c, dband_c;
  logic signed [34:0]            total_sum;
  logic signed [63:0]            gdiff_in, drive_neg;

  logic                          mul_narrow, mul_done;
  logic signed [WIDE_W-1:0]      mul_a, mul_res;
  logic signed [B_W-1:0]         mul_b;

  assign integ_sum = 33'(integ_q) + 33'(err_q);
  assign integ_new = (integ_sum[32] != integ_sum[31]) ?
                     (integ_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : integ_sum[31:0];
  assign deriv_new = (ERROR_WIDTH+1)'(err_q) - (ERROR_WIDTH+1)'(prop_q);

  assign err_c   = CMP_W'(err_q);
  assign dband_c = CMP_W'(dband_q);

  assign total_sum = 35'(prop_q) + 35'(integ_q) + 35'(deriv_q);
  assign drive_neg = -64'(sum_q);

  // Operand selection for the shared multiplier
  always_comb begin
    mul_a      = t_q;
    mul_b      = B_W'(err_q);
    mul_narrow = 1'b0;
    case (cmd_i.sel)
      SEL_P1: begin
        mul_a = WIDE_W'(gain_p_q);
        mul_b = chg_p_q;
      end
      SEL_I1: begin
        mul_a = WIDE_W'(gain_i_q);
        mul_b = chg_i_q;
      end
      SEL_D1: begin
        mul_a = WIDE_W'(gain_d_q);
        mul_b = chg_d_q;
      end
      SEL_P2, SEL_I2, SEL_D2: begin
        mul_a = t_q;
        mul_b = B_W'(err_q);
      end
      SEL_P3, SEL_I3, SEL_D3: begin
        mul_a = t_q;
        mul_b = B_W'(lrate_q);
      end
      SEL_DRV_P: begin
        mul_a      = WIDE_W'(gain_p_q);
        mul_b      = B_W'(prop_q);
        mul_narrow = 1'b1;
      end
      SEL_DRV_I: begin
        mul_a      = WIDE_W'(gain_i_q);
        mul_b      = B_W'(integ_q);
        mul_narrow = 1'b1;
      end
      SEL_DRV_D: begin
        mul_a      = WIDE_W'(gain_d_q);
        mul_b      = B_W'(deriv_q);
        mul_narrow = 1'b1;
      end
      default: begin
        mul_a = t_q;
      end
    endcase
  end

  // Gain being stepped by the current writeback
  always_comb begin
    case (cmd_i.sel)
      SEL_I3:  gdiff_in = 64'(gain_i_q) - 64'(mul_res);
      SEL_D3:  gdiff_in = 64'(gain_d_q) - 64'(mul_res);
      default: gdiff_in = 64'(gain_p_q) - 64'(mul_res);
    endcase
  end

  agpid_mul #(
    .B_W (B_W)
  ) u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.mul_start),
    .narrow_i (mul_narrow),
    .a_i      (mul_a),
    .b_i      (mul_b),
    .res_o    (mul_res),
    .done_o   (mul_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_kp_q <= INIT_KP_RST;
      init_ki_q <= INIT_KI_RST;
      init_kd_q <= INIT_KD_RST;
      en_mask_q <= EN_MASK_RST;
      lrate_q   <= LRATE_RST;
      dband_q   <= DBAND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INIT_KP:   init_kp_q <= cfg_data_i;
        CFG_INIT_KI:   init_ki_q <= cfg_data_i;
        CFG_INIT_KD:   init_kd_q <= cfg_data_i;
        CFG_EN_MASK:   en_mask_q <= cfg_data_i[2:0];
        CFG_LRATE:     lrate_q   <= cfg_data_i[15:0];
        CFG_DEAD_BAND: dband_q   <= cfg_data_i[14:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q  <= 1'b1;
      prop_q   <= '0;
      integ_q  <= '0;
      deriv_q  <= '0;
      gain_p_q <= gsat(64'(INIT_KP_RST));
      gain_i_q <= gsat(64'(INIT_KI_RST));
      gain_d_q <= gsat(64'(INIT_KD_RST));
    end else begin
      if (cmd_i.reload) begin
        prop_q   <= '0;
        integ_q  <= '0;
        deriv_q  <= '0;
        gain_p_q <= gsat(64'(init_kp_q));
        gain_i_q <= gsat(64'(init_ki_q));
        gain_d_q <= gsat(64'(init_kd_q));
      end
      if (cmd_i.first) begin
        first_q <= 1'b0;
        prop_q  <= err_q;
      end
      if (cmd_i.terms) begin
        prop_q  <= err_q;
        integ_q <= integ_new;
        deriv_q <= deriv_new;
      end
      if (cmd_i.wb) begin
        case (cmd_i.sel)
          SEL_P3:  gain_p_q <= gsat(gdiff_in);
          SEL_I3:  gain_i_q <= gsat(gdiff_in);
          SEL_D3:  gain_d_q <= gsat(gdiff_in);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      err_q <= in_err_i;
    end
    if (cmd_i.terms) begin
      chg_p_q <= B_W'(deriv_new);
      chg_i_q <= B_W'(33'(integ_new) - 33'(integ_q));
      chg_d_q <= B_W'((ERROR_WIDTH+2)'(deriv_new) - (ERROR_WIDTH+2)'(deriv_q));
    end
    if (cmd_i.reload || cmd_i.first || cmd_i.terms) begin
      sum_q <= '0;
    end else if (cmd_i.wb) begin
      if (cmd_i.sel inside {SEL_P1, SEL_P2, SEL_I1, SEL_I2, SEL_D1, SEL_D2}) begin
        t_q <= mul_res;
      end
      if ((cmd_i.sel == SEL_DRV_P && en_mask_q[0]) ||
          (cmd_i.sel == SEL_DRV_I && en_mask_q[1]) ||
          (cmd_i.sel == SEL_DRV_D && en_mask_q[2])) begin
        sum_q <= sum_q + mul_res;
      end
    end
    if (cmd_i.out_load) begin
      drive_q <= osat(drive_neg);
      total_q <= osat(64'(total_sum));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  assign sts_o.first_pending = first_q;
  assign sts_o.adapt         = err_c > dband_c;
  assign sts_o.mul_done      = mul_done;
  assign sts_o.out_free      = !out_vld_q || out_ready_i;

  assign out_valid_o = out_vld_q;
  assign drive_o     = drive_q;
  assign total_o     = total_q;

endmodule

FILE: hw/rtl/agpid_ctrl.sv
module agpid_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_reload_i,
  output logic                in_ready_o,
  input  agpid_pkg::dp_sts_t  sts_i,
  output agpid_pkg::dp_cmd_t  cmd_o
);
  import agpid_pkg::*;

  ctrl_state_e state_q, state_d;
  mul_sel_e    sel_q, sel_d;

  // Next state
  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_reload_i) begin
            state_d = ST_RELOAD;
          end else if (sts_i.first_pending) begin
            state_d = ST_FIRST;
          end else begin
            state_d = ST_TERMS;
          end
        end
      end
      ST_RELOAD: state_d = ST_OUT;
      ST_FIRST: begin
        sel_d   = SEL_DRV_P;
        state_d = ST_START;
      end
      ST_TERMS: begin
        sel_d   = sts_i.adapt ? SEL_P1 : SEL_DRV_P;
        state_d = ST_START;
      end
      ST_START: state_d = ST_WAIT;
      ST_WAIT: begin
        if (sts_i.mul_done) begin
          if (sel_q == SEL_DRV_D) begin
            state_d = ST_OUT;
          end else begin
            sel_d   = mul_sel_e'(sel_q + 4'd1);
            state_d = ST_START;
          end
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    cmd_o.sel  = sel_q;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_RELOAD: cmd_o.reload = 1'b1;
      ST_FIRST:  cmd_o.first  = 1'b1;
      ST_TERMS:  cmd_o.terms  = 1'b1;
      ST_START:  cmd_o.mul_start = 1'b1;
      ST_WAIT:   cmd_o.wb = sts_i.mul_done;
      ST_OUT:    cmd_o.out_load = sts_i.out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= SEL_P1;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
    end
  end

endmodule

FILE: hw/rtl/adaptive_gain_pid_controller.sv
// PID controller with gradient-descent gain tuning. Each input beat carries
// either a signed Q4.12 error sample (tuser low) or a reload command (tuser
// high); every beat yields exactly one result beat holding the saturated
// Q16.16 drive and the saturated P+I+D sum. A reload copies the initial gains
// into the live gains and clears the terms, giving a zero result. The first
// sample after reset only records P. When a sample lies above the dead band
// each gain takes a step of rate*gain*change*error, built as three chained
// products. All products run on one shared 63 x 16 bit digit-serial
// multiplier, so timing is set by how many products an item needs. The
// multiplier works through NDIG = ceil(max(ERROR_WIDTH+2, 32)/16) digits
// (2 at the default width) per product. A reload needs no product, a sample
// inside the dead band or the first sample needs three, and an adapting
// sample needs twelve. The input is taken only between items; a finished
// beat waits in the output register while the next item is accepted and
// worked on.
module adaptive_gain_pid_controller #(
  parameter int unsigned ERROR_WIDTH = agpid_pkg::ERROR_WIDTH_DEF,
  parameter int unsigned GAIN_WIDTH  = agpid_pkg::GAIN_WIDTH_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration writes
  input  logic                                  cfg_we_i,
  input  logic [agpid_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [agpid_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // Input beats
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [((ERROR_WIDTH+7)/8)*8-1:0]      s_axis_tdata,  // error_sample
  input  logic                                  s_axis_tuser,  // opcode
  // Result beats
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  output logic [2*agpid_pkg::OUT_W-1:0]         m_axis_tdata   // drive, total_error
);
  import agpid_pkg::*;

  dp_cmd_t                 cmd;
  dp_sts_t                 sts;
  logic signed [OUT_W-1:0] drive, total;

  // Sequencer: one item at a time, one product at a time
  agpid_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_reload_i (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Terms, gains, shared multiplier and the output register
  agpid_dp #(
    .ERROR_WIDTH (ERROR_WIDTH),
    .GAIN_WIDTH  (GAIN_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_err_i    (s_axis_tdata[ERROR_WIDTH-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .drive_o     (drive),
    .total_o     (total)
  );

  // Drive in the low word, total_error in the high word
  assign m_axis_tdata = {total, drive};

  // An accepted beat keeps the input closed for at least the next cycle
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input still open the cycle after a beat was accepted");

  // Never overwrite a result beat that has not been taken
  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("result loaded over a pending beat");

  // Products are written back only when the multiplier reports completion
  a_wb_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.wb |-> (sts.mul_done && $past(!cmd.mul_start)))
    else $error("writeback without a finished product");

  // A launch is followed by a busy multiplier, never an immediate result
  a_start_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mul_start |=> !sts.mul_done)
    else $error("multiplier reported done right after launch");

endmodule
